// File: rtl/bhc_pkg.sv
// Shared types, constants and register map of the boiler heating controller.
`default_nettype none

package bhc_pkg;

  // Timer limits, in one-second ticks.
  localparam int unsigned PumpDelayS    = 60;
  localparam int unsigned FailureDelayS = 10;

  localparam int unsigned DelayCntW = $clog2(PumpDelayS + 1);
  localparam int unsigned WdogCntW  = $clog2(FailureDelayS + 1);

  // Stream and configuration port widths.
  localparam int unsigned TempW     = 8;
  localparam int unsigned DeltaW    = 7;
  localparam int unsigned InDataW   = 3 * TempW;
  localparam int unsigned OutDataW  = 8;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    RegRoomOff   = 3'd0,
    RegRoomOn    = 3'd1,
    RegBoilerHot = 3'd2,
    RegBoilerCool= 3'd3,
    RegPumpOnD   = 3'd4,
    RegPumpOffD  = 3'd5,
    RegFanOn     = 3'd6,
    RegFanOff    = 3'd7
  } reg_idx_e;

  // Item kinds carried on tuser.
  typedef enum logic {
    KindSample = 1'b0,
    KindTick   = 1'b1
  } item_kind_e;

  // Controller modes.
  typedef enum logic [1:0] {
    ModeOff     = 2'd0,
    ModeHeating = 2'd1,
    ModeHot     = 2'd2,
    ModeCooling = 2'd3
  } ctrl_mode_e;

  // Threshold registers.
  typedef struct packed {
    logic signed [TempW-1:0] room_off_temp;
    logic signed [TempW-1:0] room_on_temp;
    logic signed [TempW-1:0] boiler_hot_temp;
    logic signed [TempW-1:0] boiler_cool_temp;
    logic [DeltaW-1:0]       pump_on_delta;
    logic [DeltaW-1:0]       pump_off_delta;
    logic signed [TempW-1:0] fan_on_temp;
    logic signed [TempW-1:0] fan_off_temp;
  } cfg_t;

  // Controller state carried from item to item.
  typedef struct packed {
    ctrl_mode_e           mode;
    logic                 heater;
    logic                 pump;
    logic                 fan;
    logic                 delay_armed;
    logic                 delay_done;
    logic [DelayCntW-1:0] delay_cnt;
    logic                 wdog_armed;
    logic [WdogCntW-1:0]  wdog_cnt;
  } ctrl_state_t;

  // One input item as held in the input register.
  typedef struct packed {
    item_kind_e              kind;
    logic signed [TempW-1:0] room_temp;
    logic signed [TempW-1:0] boiler_temp;
    logic signed [TempW-1:0] return_temp;
  } item_t;

endpackage

`default_nettype wire

// File: rtl/boiler_heating_controller_core.sv
// Top level of the boiler heating controller: stream ports, registers, pipeline.
//
//  Channel     | Direction | Transfer when          | Content
//  s_axis      | in        | tvalid & tready        | sample temperatures or tick
//  m_axis      | out       | tvalid & tready        | relay drives, mode, alarm
//  APB         | in        | psel&penable&pwrite    | threshold registers
//
// Each item is held in the input register and then passes into the result register;
// one item is taken every cycle while the result stream is not stalled.
// The controller state is updated as an item moves into the result register.
// A stalled result holds the pipeline; an empty input register still fills.
// Reset restores default thresholds, mode off and an armed watchdog.
`default_nettype none

module boiler_heating_controller_core
  import bhc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Input stream.
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] room_temp, [15:8] boiler_temp, [23:16] return_temp
  input  wire  [InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  wire                 s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // [0] heater_on, [1] pump_on, [2] fan_on, [4:3] ctrl_state, [5] alarm_pulse, [7:6] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration port.
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ApbAddrW-1:0] paddr,
  input  wire  [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t        cfg_q;
  item_t       item_q;
  logic        in_valid_q;
  logic        out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  ctrl_state_t state_q;
  ctrl_state_t state_d;
  logic        alarm;
  logic        advance;
  logic        cfg_write;
  reg_idx_e    reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_idx   = reg_idx_e'(paddr[ApbAddrW-1:2]);

  // Threshold register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.room_off_temp    <= TempW'(10);
      cfg_q.room_on_temp     <= TempW'(5);
      cfg_q.boiler_hot_temp  <= TempW'(80);
      cfg_q.boiler_cool_temp <= TempW'(70);
      cfg_q.pump_on_delta    <= DeltaW'(10);
      cfg_q.pump_off_delta   <= DeltaW'(5);
      cfg_q.fan_on_temp      <= TempW'(60);
      cfg_q.fan_off_temp     <= TempW'(50);
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegRoomOff:    cfg_q.room_off_temp    <= pwdata[TempW-1:0];
        RegRoomOn:     cfg_q.room_on_temp     <= pwdata[TempW-1:0];
        RegBoilerHot:  cfg_q.boiler_hot_temp  <= pwdata[TempW-1:0];
        RegBoilerCool: cfg_q.boiler_cool_temp <= pwdata[TempW-1:0];
        RegPumpOnD:    cfg_q.pump_on_delta    <= pwdata[DeltaW-1:0];
        RegPumpOffD:   cfg_q.pump_off_delta   <= pwdata[DeltaW-1:0];
        RegFanOn:      cfg_q.fan_on_temp      <= pwdata[TempW-1:0];
        default:       cfg_q.fan_off_temp     <= pwdata[TempW-1:0];
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      RegRoomOff:    prdata = ApbDataW'(cfg_q.room_off_temp);
      RegRoomOn:     prdata = ApbDataW'(cfg_q.room_on_temp);
      RegBoilerHot:  prdata = ApbDataW'(cfg_q.boiler_hot_temp);
      RegBoilerCool: prdata = ApbDataW'(cfg_q.boiler_cool_temp);
      RegPumpOnD:    prdata = ApbDataW'(cfg_q.pump_on_delta);
      RegPumpOffD:   prdata = ApbDataW'(cfg_q.pump_off_delta);
      RegFanOn:      prdata = ApbDataW'(cfg_q.fan_on_temp);
      default:       prdata = ApbDataW'(cfg_q.fan_off_temp);
    endcase
  end

  // Pipeline flow: the input register drains whenever the result slot is free.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.kind        <= item_kind_e'(s_axis_tuser);
      item_q.room_temp   <= s_axis_tdata[TempW-1:0];
      item_q.boiler_temp <= s_axis_tdata[2*TempW-1:TempW];
      item_q.return_temp <= s_axis_tdata[3*TempW-1:2*TempW];
    end
  end

  bhc_step u_step (
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .alarm_o (alarm)
  );

  // Controller state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode        <= ModeOff;
      state_q.heater      <= 1'b0;
      state_q.pump        <= 1'b0;
      state_q.fan         <= 1'b0;
      state_q.delay_armed <= 1'b0;
      state_q.delay_done  <= 1'b0;
      state_q.delay_cnt   <= '0;
      state_q.wdog_armed  <= 1'b1;
      state_q.wdog_cnt    <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {2'b00, alarm, state_d.mode, state_d.fan, state_d.pump, state_d.heater};
    end
  end

endmodule

`default_nettype wire

// File: rtl/bhc_step.sv
// Next-state logic of the heating controller for one sample or tick.
`default_nettype none

module bhc_step
  import bhc_pkg::*;
(
  input  wire  item_t       item_i,
  input  wire  cfg_t        cfg_i,
  input  wire  ctrl_state_t state_i,
  output ctrl_state_t       state_o,
  output logic              alarm_o
);

  logic signed [TempW+1:0] delta;
  logic signed [TempW+1:0] pump_on_ext;
  logic signed [TempW+1:0] pump_off_ext;

  // Boiler minus return temperature, compared against unsigned deltas.
  assign delta = {{2{item_i.boiler_temp[TempW-1]}}, item_i.boiler_temp}
               - {{2{item_i.return_temp[TempW-1]}}, item_i.return_temp};
  assign pump_on_ext  = {{(TempW + 2 - DeltaW){1'b0}}, cfg_i.pump_on_delta};
  assign pump_off_ext = {{(TempW + 2 - DeltaW){1'b0}}, cfg_i.pump_off_delta};

  always_comb begin
    state_o = state_i;
    alarm_o = 1'b0;
    if (item_i.kind == KindSample) begin
      state_o.wdog_cnt = '0;
      unique case (state_i.mode)
        ModeOff: begin
          state_o.heater = 1'b0;
          state_o.pump   = 1'b0;
          state_o.fan    = 1'b0;
          if (item_i.room_temp <= cfg_i.room_on_temp) state_o.mode = ModeHeating;
        end
        ModeHeating: begin
          // Later tests win where on and off thresholds overlap.
          state_o.heater = 1'b1;
          if (delta >= pump_on_ext) state_o.pump = 1'b1;
          if (delta <= pump_off_ext) state_o.pump = 1'b0;
          if (item_i.boiler_temp >= cfg_i.boiler_hot_temp) state_o.mode = ModeHot;
          if (item_i.return_temp >= cfg_i.fan_on_temp) state_o.fan = 1'b1;
          if (item_i.return_temp <= cfg_i.fan_off_temp) state_o.fan = 1'b0;
          if (item_i.room_temp >= cfg_i.room_off_temp) state_o.mode = ModeCooling;
        end
        ModeHot: begin
          state_o.pump   = 1'b1;
          state_o.heater = 1'b0;
          if (item_i.return_temp > cfg_i.fan_on_temp) state_o.fan = 1'b1;
          if (item_i.return_temp < cfg_i.fan_off_temp) state_o.fan = 1'b0;
          if (item_i.boiler_temp <= cfg_i.boiler_cool_temp) state_o.mode = ModeHeating;
          if (item_i.room_temp >= cfg_i.room_off_temp) state_o.mode = ModeCooling;
        end
        default: begin
          // Cooling: arm the pump run-on delay, then leave once it expires.
          state_o.heater = 1'b0;
          if (state_i.delay_armed) begin
            if (state_i.delay_done) begin
              state_o.delay_done  = 1'b0;
              state_o.delay_armed = 1'b0;
              state_o.delay_cnt   = '0;
              state_o.mode        = ModeOff;
            end
          end else begin
            state_o.delay_armed = 1'b1;
            state_o.delay_done  = 1'b0;
            state_o.delay_cnt   = '0;
          end
        end
      endcase
    end else begin
      // Pump delay advances until it reaches its limit.
      if (state_i.delay_armed && !state_i.delay_done) begin
        state_o.delay_cnt = state_i.delay_cnt + 1'b1;
        if (state_o.delay_cnt >= DelayCntW'(PumpDelayS)) state_o.delay_done = 1'b1;
      end
      // Sensor watchdog fires once and stays disarmed until reset.
      if (state_i.wdog_armed) begin
        state_o.wdog_cnt = state_i.wdog_cnt + 1'b1;
        if (state_o.wdog_cnt >= WdogCntW'(FailureDelayS)) begin
          state_o.wdog_armed = 1'b0;
          state_o.wdog_cnt   = '0;
          state_o.heater     = 1'b0;
          state_o.pump       = 1'b1;
          state_o.fan        = 1'b0;
          state_o.mode       = ModeOff;
          alarm_o            = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
